@@ rtl/esfd_pkg.sv @@
// shared types and constants for the escaped serial frame deframer
package esfd_pkg;

	localparam logic [7:0] SYNC_BYTE   = 8'hE0;
	localparam logic [7:0] ESCAPE_BYTE = 8'hD0;

	typedef enum logic [2:0] {
		EV_IGNORED  = 3'd0,
		EV_SYNC     = 3'd1,
		EV_ESCAPE   = 3'd2,
		EV_STORED   = 3'd3,
		EV_GOOD     = 3'd4,
		EV_MISMATCH = 3'd5
	} evt_code_t;

	typedef struct packed {
		logic      accepted;
		evt_code_t evt;
		logic [7:0] index;
		logic [7:0] value;
	} esfd_result_t;

endpackage

@@ rtl/esfd_core.sv @@
// frame state and per-byte decode for the deframer
module esfd_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	output esfd_pkg::esfd_result_t result
);
	import esfd_pkg::*;

	logic       in_frame_q;
	logic       esc_q;
	logic [7:0] count_q;
	logic [7:0] sum_q;
	logic [7:0] len_q;

	logic       in_frame_d;
	logic       esc_d;
	logic [7:0] count_d;
	logic [7:0] sum_d;
	logic [7:0] len_d;

	logic [8:0] val9;
	logic       at_trailer;

	// escaped byte is taken plus one, escaped 0xff becomes 0x100
	assign val9       = esc_q ? ({1'b0, rx_byte} + 9'd1) : {1'b0, rx_byte};
	assign at_trailer = (count_q != 8'd0) && (count_q == len_q);

	always_comb begin
		in_frame_d = in_frame_q;
		esc_d      = esc_q;
		count_d    = count_q;
		sum_d      = sum_q;
		len_d      = len_q;
		result     = '{accepted: 1'b0, evt: EV_IGNORED, index: 8'd0, value: 8'd0};
		if (rx_byte == SYNC_BYTE) begin
			in_frame_d      = 1'b1;
			esc_d           = 1'b0;
			count_d         = 8'd0;
			sum_d           = 8'd0;
			result.accepted = 1'b1;
			result.evt      = EV_SYNC;
		end else if (!in_frame_q) begin
			// idle: byte ignored, nothing changes
		end else if (rx_byte == ESCAPE_BYTE) begin
			esc_d           = 1'b1;
			result.accepted = 1'b1;
			result.evt      = EV_ESCAPE;
		end else begin
			esc_d           = 1'b0;
			result.accepted = 1'b1;
			if (at_trailer) begin
				if (val9 == {1'b0, sum_q}) begin
					in_frame_d = 1'b0;
					result.evt = EV_GOOD;
				end else begin
					result.evt = EV_MISMATCH;
				end
			end else begin
				if (count_q == 8'd0)
					len_d = val9[7:0];
				count_d      = count_q + 8'd1;
				sum_d        = sum_q + val9[7:0];
				result.evt   = EV_STORED;
				result.index = count_q;
				result.value = val9[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			count_q    <= 8'd0;
			sum_q      <= 8'd0;
			len_q      <= 8'd0;
		end else if (step) begin
			in_frame_q <= in_frame_d;
			esc_q      <= esc_d;
			count_q    <= count_d;
			sum_q      <= sum_d;
			len_q      <= len_d;
		end
	end

	a_sync_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && rx_byte == SYNC_BYTE |=> in_frame_q && !esc_q && count_q == 8'd0 && sum_q == 8'd0)
		else $error("sync did not restart the frame");

	a_store_counts: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.evt == EV_STORED |=> count_q == $past(count_q) + 8'd1)
		else $error("stored byte did not advance the count");

	a_good_idles: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.evt == EV_GOOD |=> !in_frame_q && !esc_q)
		else $error("good frame did not leave the frame");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && !result.accepted |=> $stable(count_q) && $stable(sum_q) && $stable(len_q))
		else $error("ignored byte changed frame state");

endmodule

@@ rtl/escaped_serial_frame_deframer_unit.sv @@
// top level of the escaped serial frame deframer
// path: a transferred byte is registered in s1, decoded as it moves to s2, and shown
//   from s2 with out_valid high; while s2 is blocked the byte waits in s1
// throughput: one byte per cycle unless out_stall holds s2; the decode is combinational
// reset: arst_n clears the frame state and both stage valids; no frame is active after it
module escaped_serial_frame_deframer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       accepted,
	output logic [2:0] event_res,
	output logic [7:0] byte_index,
	output logic [7:0] byte_value
);
	import esfd_pkg::*;

	// input register stage
	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	// result register stage
	logic         valid_s2;
	esfd_result_t result_s2;

	esfd_result_t result;
	logic         s2_free;
	logic         advance;
	logic         in_xfer;

	// s2 can load when empty or when its result is transferred out this cycle
	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	// s1 holds its byte only while s2 is blocked
	assign in_stall = valid_s1 && !s2_free;
	assign in_xfer  = in_valid && !in_stall;

	// decode and frame state, committed when the byte moves from s1 to s2
	esfd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.rx_byte(rx_byte_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			rx_byte_s1 <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// result payload, held while the output transfer is stalled
	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= result;
	end

	assign out_valid  = valid_s2;
	assign accepted   = result_s2.accepted;
	assign event_res  = result_s2.evt;
	assign byte_index = result_s2.index;
	assign byte_value = result_s2.value;

endmodule

@@ tb/esfd_tb_pkg.sv @@
// deframer event predictor and scoreboard class for the deframer testbench
`timescale 1ns / 1ps

package esfd_tb_pkg;

	import esfd_pkg::*;

	class deframe_checker;
		bit           in_frame;
		bit           esc_pending;
		logic [7:0]   count;
		logic [7:0]   sum;
		logic [7:0]   flen;
		esfd_result_t expected_events[$];
		int           errors;

		function new();
			in_frame    = 1'b0;
			esc_pending = 1'b0;
			count       = 8'd0;
			sum         = 8'd0;
			flen        = 8'd0;
			errors      = 0;
		endfunction

		// work out the event for one transferred byte and queue it
		function void note_rx_byte(logic [7:0] b);
			esfd_result_t r;
			logic [8:0]   v;
			r     = '0;
			r.evt = EV_IGNORED;
			if (b == SYNC_BYTE) begin
				in_frame    = 1'b1;
				count       = 8'd0;
				sum         = 8'd0;
				esc_pending = 1'b0;
				r.accepted  = 1'b1;
				r.evt       = EV_SYNC;
			end else if (in_frame) begin
				r.accepted = 1'b1;
				if (b == ESCAPE_BYTE) begin
					esc_pending = 1'b1;
					r.evt       = EV_ESCAPE;
				end else begin
					// nine bits so an escaped ff never equals the sum
					v = {1'b0, b};
					if (esc_pending) begin
						v           = v + 9'd1;
						esc_pending = 1'b0;
					end
					if (count != 8'd0 && count == flen) begin
						if (v == {1'b0, sum}) begin
							in_frame = 1'b0;
							r.evt    = EV_GOOD;
						end else begin
							r.evt = EV_MISMATCH;
						end
					end else begin
						if (count == 8'd0)
							flen = v[7:0];
						r.evt   = EV_STORED;
						r.index = count;
						r.value = v[7:0];
						count   = count + 8'd1;
						sum     = sum + v[7:0];
					end
				end
			end
			expected_events.push_back(r);
		endfunction

		function void check_result(esfd_result_t got);
			esfd_result_t want;
			if (expected_events.size() == 0) begin
				if (errors < 10)
					$display("unexpected result: acc=%0d ev=%0d idx=%0d val=%0d",
						got.accepted, got.evt, got.index, got.value);
				errors++;
				return;
			end
			want = expected_events.pop_front();
			if (got.accepted !== want.accepted || got.evt !== want.evt ||
					got.index !== want.index || got.value !== want.value) begin
				if (errors < 10)
					$display("mismatch: expected acc=%0d ev=%0d idx=%0d val=%0d, got acc=%0d ev=%0d idx=%0d val=%0d",
						want.accepted, want.evt, want.index, want.value,
						got.accepted, got.evt, got.index, got.value);
				errors++;
			end
		endfunction

		function int pending();
			return expected_events.size();
		endfunction
	endclass

endpackage

@@ tb/tb_escaped_serial_frame_deframer_unit.sv @@
// testbench top for the escaped serial frame deframer: framed and noisy byte streams
`timescale 1ns / 1ps

module tb_escaped_serial_frame_deframer_unit;

	import esfd_pkg::*;
	import esfd_tb_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       accepted;
	logic [2:0] event_res;
	logic [7:0] byte_index;
	logic [7:0] byte_value;

	// quiet turns off random idling on both sides for a stretch
	logic quiet;
	int   frame_bytes;

	deframe_checker sb = new();

	escaped_serial_frame_deframer_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.accepted   (accepted),
		.event_res  (event_res),
		.byte_index (byte_index),
		.byte_value (byte_value)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver side: stall about 17 times in a hundred, changed at the falling edge
	always @(negedge clk) begin
		out_stall <= arst_n && !quiet && ($urandom_range(0, 99) < 17);
	end

	// sample both channels at the rising edge; a byte's result passes s1 and then s2,
	// so noting the input first never races its own check
	always @(posedge clk) begin
		esfd_result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_rx_byte(rx_byte);
			if (out_valid && !out_stall) begin
				got.accepted = accepted;
				got.evt      = evt_code_t'(event_res);
				got.index    = byte_index;
				got.value    = byte_value;
				sb.check_result(got);
			end
		end
	end

	// entered and left at a falling edge; valid gets one assignment per edge
	task automatic send_byte(input logic [7:0] b);
		while (!quiet && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'($urandom_range(0, 255));
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		// hold the payload until the transfer happens
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// send one stored value, escaping where needed and now and then where not;
	// a zero trailer is never escaped since d0 ff reads as 0x100
	task automatic send_value(input logic [7:0] x, input bit trailer);
		bit may_escape;
		may_escape = !(trailer && x == 8'h00) && x != 8'hE1 && x != 8'hD1;
		if (x == SYNC_BYTE || x == ESCAPE_BYTE || (may_escape && $urandom_range(0, 9) == 0)) begin
			send_byte(ESCAPE_BYTE);
			send_byte(x - 8'd1);
		end else begin
			send_byte(x);
		end
		frame_bytes++;
	endtask

	// pause the sender until every queued event has been checked
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	// one frame: sync, length byte, data, trailer; cut_at below len truncates the
	// frame there, wrap first sends a zero-length frame of 256 bytes so the count
	// wraps and the next stored byte becomes the length
	task automatic send_frame(input int unsigned len, input bit bad_trailer,
			input int unsigned cut_at, input bit wrap);
		logic [7:0]  sum;
		logic [7:0]  x;
		int unsigned i;
		sum = 8'd0;
		send_byte(SYNC_BYTE);
		if (wrap) begin
			send_value(8'h00, 1'b0);
			for (i = 1; i < 256; i++) begin
				x = 8'($urandom_range(0, 255));
				send_value(x, 1'b0);
				sum = sum + x;
			end
		end
		for (i = 0; i < len; i++) begin
			if (i == cut_at) begin
				// broken frame, sometimes left with an escape pending
				if ($urandom_range(0, 1))
					send_byte(ESCAPE_BYTE);
				return;
			end
			x = (i == 0) ? len[7:0] : 8'($urandom_range(0, 255));
			send_value(x, 1'b0);
			sum = sum + x;
		end
		if (bad_trailer) begin
			if ($urandom_range(0, 1)) begin
				// escaped ff can never match
				send_byte(ESCAPE_BYTE);
				send_byte(8'hFF);
			end else begin
				send_value(sum + 8'($urandom_range(1, 255)), 1'b0);
			end
		end
		send_value(sum, 1'b1);
	endtask

	initial begin
		int unsigned len;
		int unsigned pick;
		int          iter;
		logic [7:0]  directed_bytes[$];
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		rx_byte     = 8'h00;
		quiet       = 1'b0;
		frame_bytes = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part:
		// idle bytes are ignored, including an escape mark
		// sync right after an escape mark resynchronizes
		// zero length frame keeps storing
		// length 3 frame with a repeated escape before ff (stored as zero), a raw ff,
		// a wrong trailer, an escaped ff trailer, then the right one
		// idle byte after a good frame, then a length 1 frame with an escaped trailer
		directed_bytes = '{8'h00, 8'hFF, ESCAPE_BYTE,
			SYNC_BYTE, ESCAPE_BYTE, SYNC_BYTE,
			8'h00, 8'h12,
			SYNC_BYTE, 8'h03, ESCAPE_BYTE, ESCAPE_BYTE, 8'hFF, 8'hFF,
			8'h11, ESCAPE_BYTE, 8'hFF, 8'h02,
			8'h55,
			SYNC_BYTE, 8'h01, ESCAPE_BYTE, 8'h00};
		foreach (directed_bytes[k])
			send_byte(directed_bytes[k]);

		// random part: the count wrap frame first, then a drain, then a stretch
		// without idling, then mostly well formed frames, some broken ones and noise
		iter = 0;
		while (frame_bytes < 400) begin
			iter++;
			// one long stretch without idling on either side
			quiet = (iter >= 3 && iter < 9);
			if (iter == 2)
				wait_drained();
			pick = $urandom_range(0, 99);
			len  = ($urandom_range(0, 99) < 4) ? $urandom_range(200, 255)
				: $urandom_range(1, 12);
			if (iter == 1)
				send_frame($urandom_range(1, 6), 1'b0, 99999, 1'b1);
			else if (iter == 40)
				send_frame(255, 1'b0, 99999, 1'b0);
			else if (pick < 70)
				send_frame(len, $urandom_range(0, 4) == 0, 99999, 1'b0);
			else if (pick < 85)
				send_frame(len, 1'b0, $urandom_range(0, len), 1'b0);
			else
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// hard limit on the run
	initial begin
		#1ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
